// ----- rtl/core/umds_pkg.sv -----
// ----------------------------------------------------------------------------
// umds_pkg
// Types, constants and the raised-cosine table of the usage meter.
// ----------------------------------------------------------------------------
package umds_pkg;

  localparam int COUNT_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int TABLE_ENTRIES = 256;
  localparam int TBL_BITS      = $clog2(TABLE_ENTRIES);
  localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int Q_W           = FRAC_BITS + 1;
  localparam int PROD_W        = 2 * Q_W;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;

  localparam logic [Q_W-1:0]    ONE_Q  = Q_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);

  localparam logic [COUNT_BITS-1:0] CAPACITY_RST = 32'd131072;
  localparam logic [Q_W-1:0]        WARN_RST     = 17'd52429;
  localparam logic [Q_W-1:0]        CRIT_RST     = 17'd62259;
  localparam logic [Q_W-1:0]        FLOOR_RST    = 17'd0;
  localparam logic [2:0]            ENABLES_RST  = 3'b111;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY      = 3'd0,
    REG_WARN          = 3'd1,
    REG_CRITICAL      = 3'd2,
    REG_CURVE_MODE    = 3'd3,
    REG_SCALE_FLOOR   = 3'd4,
    REG_EVENT_ENABLES = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CURVE_LINEAR    = 2'd0,
    CURVE_QUADRATIC = 2'd1,
    CURVE_COSINE    = 2'd2
  } curve_t;

  localparam curve_t CURVE_RST = CURVE_COSINE;

  typedef enum logic {
    OP_CONSUME = 1'b0,
    OP_RESET   = 1'b1
  } op_t;

  localparam int EN_WARN     = 0;
  localparam int EN_CRITICAL = 1;
  localparam int EN_SAT      = 2;

  typedef struct packed {
    logic        operation;
    logic [15:0] token_count;
  } usage_word_t;

  typedef struct packed {
    logic [31:0]    used_total;
    logic [31:0]    remaining;
    logic [Q_W-1:0] fill_q16;
    logic [Q_W-1:0] scale_q16;
    logic           warn_fired;
    logic           critical_fired;
    logic           saturation_fired;
    logic [31:0]    warn_total;
    logic [31:0]    critical_total;
    logic [31:0]    saturation_total;
    logic [31:0]    reset_total;
  } report_word_t;

  // raised cosine table, built at elaboration
  localparam int          Q30      = 30;
  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] ONE_Q30  = 64'd1 << Q30;
  localparam int          TAYLOR_N = 14;
  localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_N] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };

  typedef logic [Q_W-1:0] cos_table_t [0:TABLE_ENTRIES];

  function automatic logic [Q_W-1:0] raised_cos_entry(input logic [63:0] i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    x    = (PI_Q30 * i) / TABLE_ENTRIES;
    x2   = (x * x) >> Q30;
    term = ONE_Q30;
    acc  = $signed(ONE_Q30);
    for (int n = 1; n <= TAYLOR_N; n++) begin
      term = ((term * x2) >> Q30) / TAYLOR_DIV[n];
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 64'sd0;
    v = ONE_Q30 + $unsigned(acc);
    v = (v + (64'd1 << (Q30 - FRAC_BITS))) >> (Q30 - FRAC_BITS + 1);
    return v[Q_W-1:0];
  endfunction

  function automatic cos_table_t build_cos_table();
    cos_table_t t;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      if (2 * i <= TABLE_ENTRIES) t[i] = raised_cos_entry(64'(i));
      else t[i] = ONE_Q - t[TABLE_ENTRIES - i];
    end
    return t;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

// ----- rtl/core/umds_if.sv -----
// ----------------------------------------------------------------------------
// umds_if
// Valid/ready channels of the usage meter: usage words in, report words out.
// ----------------------------------------------------------------------------
interface umds_usage_if;
  logic                   valid;
  logic                   ready;
  umds_pkg::usage_word_t  word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

interface umds_report_if;
  logic                   valid;
  logic                   ready;
  umds_pkg::report_word_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

// ----- rtl/core/usage_meter_with_decay_scale_unit.sv -----
// ----------------------------------------------------------------------------
// usage_meter_with_decay_scale_unit
// Token usage meter with one-shot warn/critical/saturation events and a
// decayed scale (linear, quadratic or interpolated raised cosine).
// ----------------------------------------------------------------------------
//  channel  dir  word            handshake
//  usage    in   operation,count valid/ready
//  report   out  usage report    valid/ready
//  cfg      in   index, data     cfg_we, no read-back
//
//  One item at a time: usage ready is high only in the idle step, so a new
//  item is accepted once the last has left the final step. The bit-serial
//  fill divider and bit-serial scale multiplier do the work, between control steps.
//  Reset is synchronous; no clearing pass.
//  A stalled report holds the block in its final step; the next item may be
//  accepted while an earlier report waits.
// ----------------------------------------------------------------------------
module usage_meter_with_decay_scale_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [umds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [umds_pkg::CFG_W-1:0]       cfg_data,
  umds_usage_if.sink                       usage,
  umds_report_if.source                    report
);

  localparam int QW = umds_pkg::Q_W;
  localparam int NW = umds_pkg::COUNT_BITS;
  localparam int FB = umds_pkg::FRAC_BITS;
  localparam int TB = umds_pkg::TBL_BITS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_EVT  = 6'b000100,
    ST_LOOK = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [NW-1:0]    capacity;
  logic [QW-1:0]    warn_thr;
  logic [QW-1:0]    crit_thr;
  umds_pkg::curve_t curve_mode;
  logic [QW-1:0]    scale_floor;
  logic [2:0]       enables;

  // meter state
  logic [NW-1:0] used_count;
  logic          warn_latched;
  logic          crit_latched;
  logic          sat_latched;
  logic [31:0]   warn_counter;
  logic [31:0]   crit_counter;
  logic [31:0]   sat_counter;
  logic [31:0]   reset_counter;

  // per-item work
  logic                     op_reset;
  logic [QW-1:0]            fill;
  logic                     warn_f;
  logic                     crit_f;
  logic                     sat_f;
  logic [QW-1:0]            t0;

  logic                     accept;
  logic [NW:0]              sum;
  logic [NW-1:0]            used_next;
  logic                     full;
  logic [QW-1:0]            fill_now;
  logic                     div_done;
  logic [FB-1:0]            quotient;
  logic                     mul_start;
  logic                     mul_done;
  logic [umds_pkg::PROD_W-1:0] product;
  logic [umds_pkg::PROD_W-1:0] prod_rnd;
  logic [QW-1:0]            rnd;
  logic [umds_pkg::IDX_W-1:0] idx;
  logic [umds_pkg::IDX_W-1:0] idx1;
  logic [QW-1:0]            tab0;
  logic [QW-1:0]            tab1;
  logic [QW-1:0]            drop;
  logic [QW-1:0]            fill_gap;
  logic [QW-1:0]            frac_step;
  logic [QW-1:0]            mul_a;
  logic [QW-1:0]            mul_b;
  logic [QW-1:0]            curve_s;
  logic [QW-1:0]            scale;
  logic                     out_free;

  assign accept    = usage.valid && usage.ready;
  assign usage.ready = (state == ST_IDLE);
  assign sum       = {1'b0, used_count} + (NW+1)'(usage.word.token_count);
  assign used_next = (usage.word.operation == umds_pkg::OP_RESET) ? '0 :
                     (sum[NW] ? '1 : sum[NW-1:0]);
  assign full      = used_count >= capacity;
  assign fill_now  = full ? umds_pkg::ONE_Q : {1'b0, quotient};

  // table lookup on the registered fill
  assign idx       = fill[FB -: umds_pkg::IDX_W];
  assign idx1      = (idx == umds_pkg::IDX_W'(umds_pkg::TABLE_ENTRIES)) ? idx :
                     idx + umds_pkg::IDX_W'(1);
  assign tab0      = umds_pkg::COS_TABLE[idx];
  assign tab1      = umds_pkg::COS_TABLE[idx1];
  assign drop      = (tab0 >= tab1) ? tab0 - tab1 : '0;
  assign fill_gap  = umds_pkg::ONE_Q - fill;
  assign frac_step = {fill[FB-TB-1:0], {(TB+1){1'b0}}} >> 1;
  assign mul_a     = (curve_mode == umds_pkg::CURVE_QUADRATIC) ? fill_gap : drop;
  assign mul_b     = (curve_mode == umds_pkg::CURVE_QUADRATIC) ? fill_gap : frac_step;
  assign mul_start = (state == ST_LOOK);

  assign prod_rnd  = product + umds_pkg::HALF_P;
  assign rnd       = prod_rnd[FB +: QW];

  always_comb begin
    case (curve_mode)
      umds_pkg::CURVE_LINEAR:    curve_s = fill_gap;
      umds_pkg::CURVE_QUADRATIC: curve_s = rnd;
      umds_pkg::CURVE_COSINE:    curve_s = (rnd <= t0) ? t0 - rnd : '0;
      default:                   curve_s = umds_pkg::ONE_Q;
    endcase
    scale = (curve_s > scale_floor) ? curve_s : scale_floor;
  end

  assign out_free = !report.valid || report.ready;

  umds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (used_next),
    .divisor  (capacity),
    .done     (div_done),
    .quotient (quotient)
  );

  umds_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= umds_pkg::CAPACITY_RST;
      warn_thr    <= umds_pkg::WARN_RST;
      crit_thr    <= umds_pkg::CRIT_RST;
      curve_mode  <= umds_pkg::CURVE_RST;
      scale_floor <= umds_pkg::FLOOR_RST;
      enables     <= umds_pkg::ENABLES_RST;
    end else if (cfg_we) begin
      case (umds_pkg::cfg_reg_t'(cfg_index))
        umds_pkg::REG_CAPACITY:      capacity    <= cfg_data[NW-1:0];
        umds_pkg::REG_WARN:          warn_thr    <= cfg_data[QW-1:0];
        umds_pkg::REG_CRITICAL:      crit_thr    <= cfg_data[QW-1:0];
        umds_pkg::REG_CURVE_MODE:    curve_mode  <= umds_pkg::curve_t'(cfg_data[1:0]);
        umds_pkg::REG_SCALE_FLOOR:   scale_floor <= cfg_data[QW-1:0];
        umds_pkg::REG_EVENT_ENABLES: enables     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      used_count    <= '0;
      warn_latched  <= 1'b0;
      crit_latched  <= 1'b0;
      sat_latched   <= 1'b0;
      warn_counter  <= '0;
      crit_counter  <= '0;
      sat_counter   <= '0;
      reset_counter <= '0;
      report.valid  <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        report.valid <= 1'b1;
      end else if (report.valid && report.ready) begin
        report.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            used_count <= used_next;
            if (usage.word.operation == umds_pkg::OP_RESET) begin
              warn_latched  <= 1'b0;
              crit_latched  <= 1'b0;
              sat_latched   <= 1'b0;
              reset_counter <= reset_counter + 32'd1;
            end
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) state <= ST_EVT;
        end
        ST_EVT: begin
          if (!op_reset) begin
            if (warn_f) begin
              warn_latched <= 1'b1;
              warn_counter <= warn_counter + 32'd1;
            end
            if (crit_f) begin
              crit_latched <= 1'b1;
              crit_counter <= crit_counter + 32'd1;
            end
            if (sat_f) begin
              sat_latched <= 1'b1;
              sat_counter <= sat_counter + 32'd1;
            end
          end
          state <= ST_LOOK;
        end
        ST_LOOK: state <= ST_MUL;
        ST_MUL: begin
          if (mul_done) state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // event decisions, fill and table word
  always_ff @(posedge clk) begin
    if (accept) op_reset <= (usage.word.operation == umds_pkg::OP_RESET);
    if (state == ST_DIV && div_done) begin
      fill   <= fill_now;
      warn_f <= !op_reset && !warn_latched && (fill_now >= warn_thr) &&
                enables[umds_pkg::EN_WARN];
      crit_f <= !op_reset && !crit_latched && (fill_now >= crit_thr) &&
                enables[umds_pkg::EN_CRITICAL];
      sat_f  <= !op_reset && !sat_latched && full &&
                enables[umds_pkg::EN_SAT];
    end
    if (state == ST_LOOK) t0 <= tab0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      report.word.used_total       <= used_count[31:0];
      report.word.remaining        <= full ? '0 : capacity - used_count;
      report.word.fill_q16         <= fill;
      report.word.scale_q16        <= scale;
      report.word.warn_fired       <= warn_f;
      report.word.critical_fired   <= crit_f;
      report.word.saturation_fired <= sat_f;
      report.word.warn_total       <= warn_counter;
      report.word.critical_total   <= crit_counter;
      report.word.saturation_total <= sat_counter;
      report.word.reset_total      <= reset_counter;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !usage.ready)
    else $error("usage accepted while an item is in work");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide step");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside multiply step");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOK |-> fill <= umds_pkg::ONE_Q)
    else $error("fill above one");

  a_report_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(report.valid) |-> $past(state == ST_FIN))
    else $error("report raised outside final step");
`endif

endmodule

// ----- rtl/core/umds_div.sv -----
// ----------------------------------------------------------------------------
// umds_div
// Restoring divider, one quotient bit per cycle: q = floor(n * 2^F / d),
// valid for n < d.
// ----------------------------------------------------------------------------
module umds_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [umds_pkg::COUNT_BITS-1:0]     dividend,
  input  logic [umds_pkg::COUNT_BITS-1:0]     divisor,
  output logic                                done,
  output logic [umds_pkg::FRAC_BITS-1:0]      quotient
);

  localparam int CW = $clog2(umds_pkg::FRAC_BITS);
  localparam int NW = umds_pkg::COUNT_BITS;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsr;
  logic [NW:0]   shl;
  logic          take;

  assign shl  = {rem, 1'b0};
  assign take = shl >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(umds_pkg::FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (take) rem <= NW'(shl - {1'b0, dsr});
      else rem <= shl[NW-1:0];
      quotient <= {quotient[umds_pkg::FRAC_BITS-2:0], take};
    end
  end

endmodule

// ----- rtl/core/umds_mul.sv -----
// ----------------------------------------------------------------------------
// umds_mul
// Serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module umds_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [umds_pkg::Q_W-1:0]         a,
  input  logic [umds_pkg::Q_W-1:0]         b,
  output logic                             done,
  output logic [umds_pkg::PROD_W-1:0]      product
);

  localparam int CW = $clog2(umds_pkg::Q_W);
  localparam int PW = umds_pkg::PROD_W;

  logic                     busy;
  logic [CW-1:0]            cnt;
  logic [PW-1:0]            a_sh;
  logic [umds_pkg::Q_W-1:0] b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(umds_pkg::Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh    <= PW'(a);
      b_sh    <= b;
      product <= '0;
    end else if (busy) begin
      if (b_sh[0]) product <= product + a_sh;
      a_sh <= {a_sh[PW-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[umds_pkg::Q_W-1:1]};
    end
  end

endmodule

// ----- dv/tb_usage_meter_with_decay_scale_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usage_meter_with_decay_scale_unit
// Drives usage words through the meter and checks every report word against
// an in-bench model of the count, one-shot events, counters and decay curves.
// Directed cases cover the corner settings, then randomized phases follow.
// ----------------------------------------------------------------------------
module tb_usage_meter_with_decay_scale_unit;
  import umds_pkg::*;

  localparam int          WATCHDOG_LIMIT = 3000;
  localparam logic [1:0]  CURVE_UNUSED   = 2'd3;
  localparam longint unsigned PI_30      = 64'd3373259426;
  localparam longint unsigned UNIT_30    = 64'd1 << 30;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  umds_usage_if  usage_ch();
  umds_report_if report_ch();

  usage_meter_with_decay_scale_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .usage     (usage_ch),
    .report    (report_ch)
  );

  always #5 clk = ~clk;

  // meter model state and register copies
  logic [31:0] cap_reg    = CAPACITY_RST;
  logic [16:0] warn_reg   = WARN_RST;
  logic [16:0] crit_reg   = CRIT_RST;
  logic [1:0]  curve_reg  = CURVE_RST;
  logic [16:0] floor_reg  = FLOOR_RST;
  logic [2:0]  enable_reg = ENABLES_RST;

  logic [31:0] count_model  = '0;
  logic        warn_seen    = 1'b0;
  logic        crit_seen    = 1'b0;
  logic        sat_seen     = 1'b0;
  logic [31:0] warn_hits    = '0;
  logic [31:0] crit_events  = '0;
  logic [31:0] sat_events   = '0;
  logic [31:0] reset_events = '0;

  longint unsigned raised_cos [0:TABLE_ENTRIES];

  report_word_t pending_reports [$];
  int           mismatches = 0;
  int           reports_seen = 0;
  bit           idle_on = 1'b1;
  int           stall_left = 0;
  int           quiet_cycles = 0;

  function automatic longint unsigned cos_entry(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          acc;
    x    = (PI_30 * i) / TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = UNIT_30;
    acc  = longint'(UNIT_30);
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = UNIT_30 + $unsigned(acc);
    return (v + (64'd1 << (30 - FRAC_BITS))) >> (30 - FRAC_BITS + 1);
  endfunction

  function automatic logic [16:0] fill_of_used(logic [31:0] used);
    if (cap_reg == 0 || used >= cap_reg) return ONE_Q;
    return 17'((64'(used) << FRAC_BITS) / 64'(cap_reg));
  endfunction

  function automatic logic [16:0] decay_scale(logic [16:0] fill);
    longint unsigned d;
    longint unsigned s;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned fr;
    longint unsigned t0;
    longint unsigned t1;
    longint unsigned drop;
    longint unsigned dec;
    d = 64'(ONE_Q) - 64'(fill);
    case (curve_reg)
      CURVE_LINEAR: begin
        s = d;
      end
      CURVE_QUADRATIC: begin
        s = (d * d + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      end
      CURVE_COSINE: begin
        pos = 64'(fill) * TABLE_ENTRIES;
        idx = pos >> FRAC_BITS;
        fr  = pos & ((64'd1 << FRAC_BITS) - 1);
        if (idx >= TABLE_ENTRIES) begin
          s = raised_cos[TABLE_ENTRIES];
        end else begin
          t0   = raised_cos[idx];
          t1   = raised_cos[idx + 1];
          drop = (t0 >= t1) ? t0 - t1 : 0;
          dec  = (drop * fr + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          s    = (dec <= t0) ? t0 - dec : 0;
        end
      end
      default: begin
        s = 64'(ONE_Q);
      end
    endcase
    return (s > 64'(floor_reg)) ? 17'(s) : floor_reg;
  endfunction

  function automatic report_word_t meter_step(op_t op, logic [15:0] tok);
    report_word_t r;
    logic [32:0]  sum;
    r = '0;
    if (op == OP_RESET) begin
      count_model  = '0;
      warn_seen    = 1'b0;
      crit_seen    = 1'b0;
      sat_seen     = 1'b0;
      reset_events = reset_events + 1;
    end else begin
      sum         = {1'b0, count_model} + 33'(tok);
      count_model = sum[32] ? '1 : sum[31:0];
    end
    r.fill_q16 = fill_of_used(count_model);
    if (op == OP_CONSUME) begin
      if (!warn_seen && r.fill_q16 >= warn_reg && enable_reg[EN_WARN]) begin
        warn_seen    = 1'b1;
        warn_hits    = warn_hits + 1;
        r.warn_fired = 1'b1;
      end
      if (!crit_seen && r.fill_q16 >= crit_reg && enable_reg[EN_CRITICAL]) begin
        crit_seen        = 1'b1;
        crit_events      = crit_events + 1;
        r.critical_fired = 1'b1;
      end
      if (!sat_seen && count_model >= cap_reg && enable_reg[EN_SAT]) begin
        sat_seen           = 1'b1;
        sat_events         = sat_events + 1;
        r.saturation_fired = 1'b1;
      end
    end
    r.used_total       = count_model;
    r.remaining        = (count_model >= cap_reg) ? '0 : cap_reg - count_model;
    r.scale_q16        = decay_scale(r.fill_q16);
    r.warn_total       = warn_hits;
    r.critical_total   = crit_events;
    r.saturation_total = sat_events;
    r.reset_total      = reset_events;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH report %0d: %s", $time, reports_seen, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  task automatic check_report(report_word_t got);
    report_word_t want;
    reports_seen++;
    if (pending_reports.size() == 0) begin
      report_mismatch("report word with no usage word pending");
      return;
    end
    want = pending_reports.pop_front();
    check_field("used_total", got.used_total, want.used_total);
    check_field("remaining", got.remaining, want.remaining);
    check_field("fill_q16", 32'(got.fill_q16), 32'(want.fill_q16));
    check_field("scale_q16", 32'(got.scale_q16), 32'(want.scale_q16));
    check_field("warn_fired", 32'(got.warn_fired), 32'(want.warn_fired));
    check_field("critical_fired", 32'(got.critical_fired), 32'(want.critical_fired));
    check_field("saturation_fired", 32'(got.saturation_fired),
                32'(want.saturation_fired));
    check_field("warn_total", got.warn_total, want.warn_total);
    check_field("critical_total", got.critical_total, want.critical_total);
    check_field("saturation_total", got.saturation_total, want.saturation_total);
    check_field("reset_total", got.reset_total, want.reset_total);
  endtask

  // report side: check, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && report_ch.valid && report_ch.ready) begin
      check_report(report_ch.word);
    end
    if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    if (stall_left > 0) begin
      report_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      report_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (usage_ch.valid && usage_ch.ready) ||
        (report_ch.valid && report_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_usage(op_t op, logic [15:0] tok);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      usage_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    usage_ch.valid                  <= 1'b1;
    usage_ch.word.operation   <= op;
    usage_ch.word.token_count <= tok;
    @(posedge clk);
    while (!usage_ch.ready) @(posedge clk);
    pending_reports.push_back(meter_step(op, tok));
  endtask

  task automatic wait_reports_drained();
    usage_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_meter_regs(logic [31:0] cap, logic [16:0] warn, logic [16:0] crit,
                                  logic [1:0] curve, logic [16:0] flr, logic [2:0] en);
    wait_reports_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_index <= REG_WARN;
    cfg_data  <= 32'(warn);
    @(posedge clk);
    cfg_index <= REG_CRITICAL;
    cfg_data  <= 32'(crit);
    @(posedge clk);
    cfg_index <= REG_CURVE_MODE;
    cfg_data  <= 32'(curve);
    @(posedge clk);
    cfg_index <= REG_SCALE_FLOOR;
    cfg_data  <= 32'(flr);
    @(posedge clk);
    cfg_index <= REG_EVENT_ENABLES;
    cfg_data  <= 32'(en);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cap_reg    = cap;
    warn_reg   = warn;
    crit_reg   = crit;
    curve_reg  = curve;
    floor_reg  = flr;
    enable_reg = en;
  endtask

  // fill-and-reset runs with random content plus stray resets and wide counts
  task automatic run_usage_burst(int n, int unsigned step_max, bit with_pauses);
    for (int k = 0; k < n; k++) begin
      if (with_pauses && $urandom_range(0, 49) == 0) begin
        wait_reports_drained();
      end
      if (count_model >= cap_reg && $urandom_range(0, 2) == 0) begin
        send_usage(OP_RESET, 16'($urandom()));
      end else if ($urandom_range(0, 29) == 0) begin
        send_usage(OP_RESET, 16'($urandom()));
      end else if ($urandom_range(0, 7) == 0) begin
        send_usage(OP_CONSUME, 16'($urandom()));
      end else begin
        send_usage(OP_CONSUME, 16'($urandom_range(0, step_max)));
      end
    end
  endtask

  function automatic int unsigned step_for_capacity(logic [31:0] cap);
    longint unsigned s;
    s = (cap == 0) ? 65535 : 64'(cap) / 12 + 1;
    return (s > 65535) ? 65535 : int'(s);
  endfunction

  task automatic test_reset_defaults();
    send_usage(OP_CONSUME, 16'd0);
    send_usage(OP_CONSUME, 16'hFFFF);
    send_usage(OP_CONSUME, 16'hFFFF);
    send_usage(OP_CONSUME, 16'd2);
    send_usage(OP_RESET, 16'hFFFF);
  endtask

  task automatic test_zero_capacity();
    write_meter_regs(32'd0, 17'd0, 17'd65536, CURVE_LINEAR, 17'd0, 3'b111);
    send_usage(OP_CONSUME, 16'd0);
    send_usage(OP_CONSUME, 16'hFFFF);
    send_usage(OP_RESET, 16'd0);
  endtask

  // unused curve, floor and warn threshold above one, saturation disabled
  task automatic test_wide_capacity();
    write_meter_regs(32'hFFFF_FFFF, 17'h1FFFF, 17'd0, CURVE_UNUSED, 17'h1FFFF,
                     3'((1 << EN_WARN) | (1 << EN_CRITICAL)));
    send_usage(OP_CONSUME, 16'hFFFF);
    send_usage(OP_CONSUME, 16'd0);
    send_usage(OP_RESET, 16'h5A5A);
  endtask

  task automatic test_late_enable();
    write_meter_regs(32'd100, 17'd32768, 17'd65535, CURVE_QUADRATIC, 17'd16384, 3'b000);
    send_usage(OP_CONSUME, 16'd50);
    write_meter_regs(32'd100, 17'd32768, 17'd65535, CURVE_QUADRATIC, 17'd16384, 3'b111);
    send_usage(OP_CONSUME, 16'd0);
    send_usage(OP_CONSUME, 16'd50);
    send_usage(OP_CONSUME, 16'hFFFF);
    send_usage(OP_RESET, 16'd1);
  endtask

  task automatic test_cosine_points();
    write_meter_regs(32'd65536, 17'd65536, 17'd65536, CURVE_COSINE, 17'd0,
                     3'(1 << EN_SAT));
    send_usage(OP_CONSUME, 16'd1);
    send_usage(OP_CONSUME, 16'd32767);
    send_usage(OP_CONSUME, 16'd32767);
    send_usage(OP_CONSUME, 16'd1);
    send_usage(OP_RESET, 16'd0);
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    logic [31:0] cap;
    logic [16:0] warn;
    logic [16:0] crit;
    logic [1:0]  curve;
    logic [16:0] flr;
    logic [2:0]  en;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 9))
        0:       cap = 32'd0;
        1:       cap = 32'hFFFF_FFFF;
        2:       cap = $urandom();
        3, 4:    cap = $urandom_range(1, 2000);
        default: cap = $urandom_range(2000, 800000);
      endcase
      warn  = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(65537, 131071))
                                          : 17'($urandom_range(0, 65536));
      crit  = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(65537, 131071))
                                          : 17'($urandom_range(0, 65536));
      curve = ($urandom_range(0, 7) == 0) ? CURVE_UNUSED : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
        3, 4:    flr = 17'($urandom_range(0, 65536));
        5:       flr = 17'($urandom_range(0, 131071));
        default: flr = 17'd0;
      endcase
      en = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
      write_meter_regs(cap, warn, crit, curve, flr, en);
      idle_on = ($urandom_range(0, 3) != 0);
      run_usage_burst(per_phase, step_for_capacity(cap), 1'b1);
    end
  endtask

  task automatic test_back_to_back(int n);
    idle_on = 1'b0;
    write_meter_regs(32'd300000, WARN_RST, CRIT_RST, 2'($urandom_range(0, 2)),
                     FLOOR_RST, ENABLES_RST);
    run_usage_burst(n, step_for_capacity(32'd300000), 1'b0);
  endtask

  initial begin
    usage_ch.valid <= 1'b0;
    usage_ch.word  <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_CAPACITY;
    cfg_data       <= '0;
    rst            <= 1'b1;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      raised_cos[i] = (2 * i <= TABLE_ENTRIES) ? cos_entry(i)
                                               : 64'(ONE_Q) - raised_cos[TABLE_ENTRIES - i];
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_zero_capacity();
    test_wide_capacity();
    test_late_enable();
    test_cosine_points();
    test_random_phases(14, 100);
    test_back_to_back(130);

    wait_reports_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/umds_pkg.sv
rtl/core/umds_if.sv
rtl/core/umds_div.sv
rtl/core/umds_mul.sv
rtl/core/usage_meter_with_decay_scale_unit.sv
dv/tb_usage_meter_with_decay_scale_unit.sv
